### src/assert_macros.svh
// assertion macros used by the motion integrator controller
// assertions compile out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked only outside reset
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// next-cycle implication, checked only outside reset
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

### src/mi2d_pkg.sv
// shared types, codes and helpers of the 2d motion integrator
// no dependencies; used by every module of the block
`default_nettype none

package mi2d_pkg;

   // csr address decode
   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   // register indexes
   localparam logic [2:0] REG_ACCEL_X       = 3'd0;
   localparam logic [2:0] REG_ACCEL_Y       = 3'd1;
   localparam logic [2:0] REG_DRAG_X        = 3'd2;
   localparam logic [2:0] REG_DRAG_Y        = 3'd3;
   localparam logic [2:0] REG_MAX_SPEED     = 3'd4;
   localparam logic [2:0] REG_GRAVITY_ACCEL = 3'd5;
   localparam logic [2:0] REG_MOVABLE_AXES  = 3'd6;
   localparam logic [2:0] REG_ACTIVE        = 3'd7;

   // register reset values
   localparam logic [30:0] DRAG_X_RESET   = 31'd52428800;
   localparam logic [1:0]  MOVABLE_RESET  = 2'b11;
   localparam logic        ACTIVE_RESET   = 1'b1;

   // action codes
   localparam logic [1:0] ACT_TICK     = 2'd0;
   localparam logic [1:0] ACT_LOAD_VEL = 2'd1;
   localparam logic [1:0] ACT_LOAD_POS = 2'd2;

   // axis select
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   // saturation bounds in the widened sum domain
   localparam logic signed [33:0] SAT_MAX = 34'sh0_7FFF_FFFF;
   localparam logic signed [33:0] SAT_MIN = -34'sh0_8000_0000;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        time_step;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic [30:0]        drag_x;
      logic [30:0]        drag_y;
      logic [30:0]        max_speed;
      logic signed [31:0] gravity_accel;
      logic [1:0]         movable_axes;
      logic               active;
   } cfg_type;

   // multiplier operand select
   typedef enum logic [1:0] {
      MUL_ACCEL   = 2'd0,
      MUL_GRAVITY = 2'd1,
      MUL_MID     = 2'd2
   } mul_sel_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      logic        load_vel;
      logic        load_pos;
      logic        axis;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        apply_en;
      logic        target_en;
      logic        half_en;
      logic        commit_en;
      logic        rsp_load;
   } cmd_type;

   // status seen by the controller
   typedef struct packed {
      logic [1:0] action;
      logic       active;
      logic [1:0] movable;
   } sts_type;

   // clamp a widened sum to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [33:0] value);
      logic signed [31:0] result;
      if (value > SAT_MAX) begin
         result = 32'sh7FFF_FFFF;
      end else if (value < SAT_MIN) begin
         result = 32'sh8000_0000;
      end else begin
         result = $signed(value[31:0]);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

### src/mi2d_csr.sv
// configuration register file of the 2d motion integrator, apb-style
// depends on mi2d_pkg
`default_nettype none

module mi2d_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [mi2d_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  wire logic [mi2d_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic      [mi2d_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                       csr_pready,
   output mi2d_pkg::cfg_type                          cfg
);

   mi2d_pkg::cfg_type cfg_ff;
   mi2d_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [2:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            mi2d_pkg::REG_ACCEL_X:       cfg_in.accel_x       = $signed(csr_pwdata);
            mi2d_pkg::REG_ACCEL_Y:       cfg_in.accel_y       = $signed(csr_pwdata);
            mi2d_pkg::REG_DRAG_X:        cfg_in.drag_x        = csr_pwdata[30:0];
            mi2d_pkg::REG_DRAG_Y:        cfg_in.drag_y        = csr_pwdata[30:0];
            mi2d_pkg::REG_MAX_SPEED:     cfg_in.max_speed     = csr_pwdata[30:0];
            mi2d_pkg::REG_GRAVITY_ACCEL: cfg_in.gravity_accel = $signed(csr_pwdata);
            mi2d_pkg::REG_MOVABLE_AXES:  cfg_in.movable_axes  = csr_pwdata[1:0];
            mi2d_pkg::REG_ACTIVE:        cfg_in.active        = csr_pwdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_x       <= '0;
         cfg_ff.accel_y       <= '0;
         cfg_ff.drag_x        <= mi2d_pkg::DRAG_X_RESET;
         cfg_ff.drag_y        <= '0;
         cfg_ff.max_speed     <= '0;
         cfg_ff.gravity_accel <= '0;
         cfg_ff.movable_axes  <= mi2d_pkg::MOVABLE_RESET;
         cfg_ff.active        <= mi2d_pkg::ACTIVE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      unique case (reg_idx)
         mi2d_pkg::REG_ACCEL_X:       csr_prdata = cfg_ff.accel_x;
         mi2d_pkg::REG_ACCEL_Y:       csr_prdata = cfg_ff.accel_y;
         mi2d_pkg::REG_DRAG_X:        csr_prdata = {1'b0, cfg_ff.drag_x};
         mi2d_pkg::REG_DRAG_Y:        csr_prdata = {1'b0, cfg_ff.drag_y};
         mi2d_pkg::REG_MAX_SPEED:     csr_prdata = {1'b0, cfg_ff.max_speed};
         mi2d_pkg::REG_GRAVITY_ACCEL: csr_prdata = cfg_ff.gravity_accel;
         mi2d_pkg::REG_MOVABLE_AXES:  csr_prdata = {30'd0, cfg_ff.movable_axes};
         mi2d_pkg::REG_ACTIVE:        csr_prdata = {31'd0, cfg_ff.active};
      endcase
   end

endmodule

`default_nettype wire

### src/mi2d_ctrl.sv
// sequencing controller of the 2d motion integrator
// depends on mi2d_pkg and assert_macros.svh; drives the datapath by command struct
`default_nettype none
`include "assert_macros.svh"

module mi2d_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire mi2d_pkg::sts_type  sts,
   output mi2d_pkg::cmd_type       cmd
);

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_MUL_ACC = 8'b0000_0010,
      ST_APPLY   = 8'b0000_0100,
      ST_TARGET  = 8'b0000_1000,
      ST_HALF    = 8'b0001_0000,
      ST_MUL_MID = 8'b0010_0000,
      ST_COMMIT  = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      axis_ff;
   logic      axis_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      tick_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign tick_go   = (sts.action == mi2d_pkg::ACT_TICK) && sts.active &&
                      (sts.movable != 2'b00);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.axis     = axis_ff;
      cmd.mul_sel  = mi2d_pkg::MUL_ACCEL;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (tick_go) begin
                  axis_in  = sts.movable[0] ? mi2d_pkg::AXIS_X : mi2d_pkg::AXIS_Y;
                  state_in = ST_MUL_ACC;
               end else begin
                  cmd.load_vel = (sts.action == mi2d_pkg::ACT_LOAD_VEL);
                  cmd.load_pos = (sts.action == mi2d_pkg::ACT_LOAD_POS);
                  state_in     = ST_DONE;
               end
            end
         end
         ST_MUL_ACC: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mi2d_pkg::MUL_ACCEL;
            state_in    = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply_en = 1'b1;
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = mi2d_pkg::MUL_GRAVITY;
            state_in     = ST_TARGET;
         end
         ST_TARGET: begin
            cmd.target_en = 1'b1;
            state_in      = ST_HALF;
         end
         ST_HALF: begin
            cmd.half_en = 1'b1;
            state_in    = ST_MUL_MID;
         end
         ST_MUL_MID: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = mi2d_pkg::MUL_MID;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit_en = 1'b1;
            if (axis_ff == mi2d_pkg::AXIS_X && sts.movable[1]) begin
               axis_in  = mi2d_pkg::AXIS_Y;
               state_in = ST_MUL_ACC;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // post the result once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= mi2d_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // an enabled tick starts the first axis
   `ASSERT_NEXT(a_tick_starts, clock, reset, state_ff == ST_IDLE && req_valid && tick_go, state_ff == ST_MUL_ACC)
   // x axis hands over to y when y is movable
   `ASSERT_NEXT(a_x_then_y, clock, reset, state_ff == ST_COMMIT && axis_ff == mi2d_pkg::AXIS_X && sts.movable[1], state_ff == ST_MUL_ACC && axis_ff == mi2d_pkg::AXIS_Y)
   // a finished item is posted and the controller frees up
   `ASSERT_NEXT(a_result_posted, clock, reset, state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == ST_IDLE)

endmodule

`default_nettype wire

### src/mi2d_dpath.sv
// datapath of the 2d motion integrator: state registers, shared multiplier,
// velocity update steps and result register; depends on mi2d_pkg
`default_nettype none

module mi2d_dpath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mi2d_pkg::cmd_type  cmd,
   input  wire mi2d_pkg::cfg_type  cfg,
   input  wire mi2d_pkg::req_type  req_data,
   output mi2d_pkg::rsp_type       rsp_data
);

   // body state
   logic signed [31:0] pos_x_ff, pos_x_in;
   logic signed [31:0] pos_y_ff, pos_y_in;
   logic signed [31:0] vel_x_ff, vel_x_in;
   logic signed [31:0] vel_y_ff, vel_y_in;

   // working registers
   logic [15:0]        step_ff, step_in;
   logic signed [31:0] scaled_ff, scaled_in;
   logic signed [31:0] vtmp_ff, vtmp_in;
   logic signed [31:0] tgt_ff, tgt_in;
   logic signed [31:0] half_ff, half_in;
   logic signed [31:0] mid_ff, mid_in;
   mi2d_pkg::rsp_type  rsp_ff, rsp_in;

   logic signed [31:0] vel_cur;
   logic signed [31:0] pos_cur;
   logic signed [31:0] acc_cur;
   logic [30:0]        drag_cur;
   logic signed [31:0] mul_a;
   logic signed [16:0] step_s;
   logic signed [48:0] product;
   logic signed [33:0] drag_ext;
   logic signed [33:0] vel_minus;
   logic signed [33:0] vel_plus;
   logic signed [31:0] applied;
   logic signed [31:0] grav_sum;
   logic signed [33:0] speed_ext;
   logic signed [33:0] speed_neg;
   logic signed [31:0] clamped;
   logic signed [33:0] diff;
   logic signed [33:0] half_full;
   logic signed [31:0] vel_new;
   logic signed [31:0] pos_new;

   // operands of the axis in work
   assign vel_cur  = (cmd.axis == mi2d_pkg::AXIS_Y) ? vel_y_ff : vel_x_ff;
   assign pos_cur  = (cmd.axis == mi2d_pkg::AXIS_Y) ? pos_y_ff : pos_x_ff;
   assign acc_cur  = (cmd.axis == mi2d_pkg::AXIS_Y) ? cfg.accel_y : cfg.accel_x;
   assign drag_cur = (cmd.axis == mi2d_pkg::AXIS_Y) ? cfg.drag_y : cfg.drag_x;

   // shared rate times step multiplier, floor shift by 16
   always_comb begin
      case (cmd.mul_sel)
         mi2d_pkg::MUL_ACCEL:   mul_a = acc_cur;
         mi2d_pkg::MUL_GRAVITY: mul_a = cfg.gravity_accel;
         mi2d_pkg::MUL_MID:     mul_a = mid_ff;
         default:               mul_a = mid_ff;
      endcase
   end
   assign step_s    = $signed({1'b0, step_ff});
   assign product   = mul_a * step_s;
   assign scaled_in = cmd.mul_en ? $signed(product[47:16]) : scaled_ff;

   // acceleration, or drag toward zero without overshoot
   assign drag_ext  = $signed({3'b000, drag_cur});
   assign vel_minus = 34'(vel_cur) - drag_ext;
   assign vel_plus  = 34'(vel_cur) + drag_ext;
   always_comb begin
      if (acc_cur != 32'sd0) begin
         applied = mi2d_pkg::sat32(34'(vel_cur) + 34'(scaled_ff));
      end else if (drag_cur != 31'd0) begin
         if (vel_minus > 34'sd0) begin
            applied = $signed(vel_minus[31:0]);
         end else if (vel_plus < 34'sd0) begin
            applied = $signed(vel_plus[31:0]);
         end else begin
            applied = 32'sd0;
         end
      end else begin
         applied = vel_cur;
      end
   end
   assign vtmp_in = cmd.apply_en ? applied : vtmp_ff;

   // gravity on y, then the speed limit
   assign grav_sum  = (cmd.axis == mi2d_pkg::AXIS_Y && cfg.gravity_accel != 32'sd0) ?
                      mi2d_pkg::sat32(34'(vtmp_ff) + 34'(scaled_ff)) : vtmp_ff;
   assign speed_ext = $signed({3'b000, cfg.max_speed});
   assign speed_neg = -speed_ext;
   always_comb begin
      if (cfg.max_speed != 31'd0 && 34'(grav_sum) > speed_ext) begin
         clamped = $signed(speed_ext[31:0]);
      end else if (cfg.max_speed != 31'd0 && 34'(grav_sum) < speed_neg) begin
         clamped = $signed(speed_neg[31:0]);
      end else begin
         clamped = grav_sum;
      end
   end
   assign tgt_in = cmd.target_en ? clamped : tgt_ff;

   // half change and midpoint velocity
   assign diff      = 34'(tgt_ff) - 34'(vel_cur);
   assign half_full = diff >>> 1;
   assign half_in   = cmd.half_en ? $signed(half_full[31:0]) : half_ff;
   assign mid_in    = cmd.half_en ? mi2d_pkg::sat32(34'(vel_cur) + half_full) : mid_ff;

   // final velocity and position of the axis
   assign vel_new = mi2d_pkg::sat32(34'(mid_ff) + 34'(half_ff));
   assign pos_new = mi2d_pkg::sat32(34'(pos_cur) + 34'(scaled_ff));

   // body state next values
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      if (cmd.load_vel) begin
         vel_x_in = req_data.value_x;
         vel_y_in = req_data.value_y;
      end
      if (cmd.load_pos) begin
         pos_x_in = req_data.value_x;
         pos_y_in = req_data.value_y;
      end
      if (cmd.commit_en) begin
         if (cmd.axis == mi2d_pkg::AXIS_Y) begin
            vel_y_in = vel_new;
            pos_y_in = pos_new;
         end else begin
            vel_x_in = vel_new;
            pos_x_in = pos_new;
         end
      end
   end

   assign step_in = cmd.capture ? req_data.time_step : step_ff;

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.pos_x = pos_x_ff;
         rsp_in.pos_y = pos_y_ff;
         rsp_in.vel_x = vel_x_ff;
         rsp_in.vel_y = vel_y_ff;
      end
   end
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      scaled_ff <= scaled_in;
      vtmp_ff   <= vtmp_in;
      tgt_ff    <= tgt_in;
      half_ff   <= half_in;
      mid_ff    <= mid_in;
      rsp_ff    <= rsp_in;
   end

endmodule

`default_nettype wire

### src/motion_integrator_2d_top.sv
// 2d motion integrator with drag, gravity and speed limit in signed Q16.16
//
// req channel: one item per transfer; action selects tick (time_step in
// Q0.16 seconds), load velocity or load position (value_x, value_y).
// rsp channel: one result per item with position and velocity after it.
// csr port: apb-style, registers at byte address 4*index, always ready,
// written only while the block is idle: the user must keep to this, the
// block does not enforce it. a load, an unused action or a frozen tick
// goes straight to the result; a tick runs per movable axis: multiply
// acceleration, apply acceleration or drag while multiplying gravity,
// add gravity and limit the speed, halve the change, multiply midpoint
// velocity into displacement and commit, all on the shared multiplier.
// one item is in work at a time; the next one is taken while the result
// still sits in the output register.
// a stalled receiver holds the result; a finished item waits until the
// output register is free.
// reset (synchronous, active high) zeroes position and velocity and
// restores the register defaults.
// depends on mi2d_pkg, mi2d_csr, mi2d_ctrl, mi2d_dpath
`default_nettype none

module motion_integrator_2d_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire mi2d_pkg::req_type                     req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output mi2d_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [mi2d_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  wire logic [mi2d_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic      [mi2d_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                       csr_pready
);

   mi2d_pkg::cfg_type cfg;
   mi2d_pkg::cmd_type cmd;
   mi2d_pkg::sts_type sts;

   // status for the controller
   assign sts.action  = req_data.action;
   assign sts.active  = cfg.active;
   assign sts.movable = cfg.movable_axes;

   mi2d_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mi2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mi2d_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
